// ===== design/uses_pkg.sv =====
// Shared constants, codes and types of the ungapped seed extension scorer.
package uses_pkg;

    localparam int ALPHABET_SIZE = 32;
    localparam int SCORE_WIDTH   = 16;
    localparam int LETTER_W      = 5;
    localparam int TV_W          = 8;
    localparam int TAG_W         = 16;
    localparam int OUT_W         = 16;
    localparam int THR_W         = 16;
    localparam int PAIR_W        = 10;
    localparam int OP_W          = 2;
    localparam int TBL_DEPTH     = ALPHABET_SIZE * ALPHABET_SIZE;
    localparam int TBL_AW        = $clog2(TBL_DEPTH);
    localparam int CMP_W         = (SCORE_WIDTH > OUT_W) ? SCORE_WIDTH : OUT_W;

    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam int S_FIELDS_W    = 2 * LETTER_W + TV_W + TAG_W;
    localparam int S_TDATA_W     = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W    = OUT_W + 1 + TAG_W;
    localparam int M_TDATA_W     = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W       = M_TDATA_W - M_FIELDS_W;

    localparam logic [PAIR_W-1:0] LIMIT_RESET = 10'd1023;

    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_RIGHT  = 2'd1;
    localparam logic [OP_W-1:0] OP_LEFT   = 2'd2;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_LIMIT  = 2'd2;

    typedef logic signed [SCORE_WIDTH-1:0] t_score;
    typedef logic signed [TV_W-1:0]        t_tv;

    typedef struct packed {
        logic             valid;
        logic             fin;
        logic             restart;
        logic             count;
        logic             in_alpha;
        logic [TAG_W-1:0] tag;
    } t_pair_ctl;

endpackage

// ===== design/ungapped_seed_extension_scorer_top.sv =====
// Top level of the ungapped seed extension scorer with its configuration registers.
//
// Items arrive on the slave stream (i_s_*). tuser carries the operation code:
// table write, right pair, left pair or finish. Table writes fill the signed
// substitution table; pairs look up one table entry each and, within the side
// limit, add it to the running score of the current hit while the best score
// is tracked. A finish transfer produces one result on the master stream (o_m_*)
// with the best score, the pass flag against the threshold and the echoed hit tag.
// One item is taken every cycle while input ready is high. A pair reads the table
// memory in the cycle of its transfer and is scored in the next cycle from the
// registered read data. A finish result passes the stage register and is then
// loaded into the output register, from which it can be taken. The output
// register lets pairs and table writes keep flowing while a result waits;
// input ready drops only when a second finish reaches the scoring stage while
// the previous result has not been taken.
// Reset clears the hit state, sets the threshold to zero and both side limits
// to 1023. The table is not cleared and must be written before use.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data; the user
// must do so only while no item is in flight, which the block does not enforce.
module ungapped_seed_extension_scorer_top import uses_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // letter_a [4:0], letter_b [9:5], table_value [17:10], hit_tag [33:18]
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    // operation [1:0]
    input  logic [OP_W-1:0]       i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // best_score [15:0], passes [16], result_tag [32:17]
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic signed [THR_W-1:0] r_threshold;
    logic [PAIR_W-1:0]       r_right_limit;
    logic [PAIR_W-1:0]       r_left_limit;
    logic                    accept;
    logic                    stall;
    logic [LETTER_W-1:0]     letter_a;
    logic [LETTER_W-1:0]     letter_b;
    t_tv                     table_value;
    logic [TAG_W-1:0]        hit_tag;
    logic                    tbl_we;
    logic                    tbl_re;
    logic [TBL_AW-1:0]       tbl_addr;
    t_tv                     tbl_rdata;
    t_pair_ctl               s1;
    logic [OUT_W-1:0]        best;
    logic                    passes;
    logic [TAG_W-1:0]        result_tag;

    assign letter_a    = i_s_tdata[LETTER_W-1:0];
    assign letter_b    = i_s_tdata[2*LETTER_W-1:LETTER_W];
    assign table_value = i_s_tdata[2*LETTER_W+TV_W-1:2*LETTER_W];
    assign hit_tag     = i_s_tdata[S_FIELDS_W-1:2*LETTER_W+TV_W];

    assign o_s_tready = !stall;
    assign accept     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= '0;
            r_right_limit <= LIMIT_RESET;
            r_left_limit  <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_THRESHOLD:   r_threshold   <= THR_W'(i_cfg_data);
                REG_RIGHT_LIMIT: r_right_limit <= i_cfg_data[PAIR_W-1:0];
                REG_LEFT_LIMIT:  r_left_limit  <= i_cfg_data[PAIR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    uses_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_op          (i_s_tuser),
        .i_letter_a    (letter_a),
        .i_letter_b    (letter_b),
        .i_tag         (hit_tag),
        .i_right_limit (r_right_limit),
        .i_left_limit  (r_left_limit),
        .i_advance     (!stall),
        .o_tbl_we      (tbl_we),
        .o_tbl_re      (tbl_re),
        .o_tbl_addr    (tbl_addr),
        .o_s1          (s1)
    );

    uses_table u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_re    (tbl_re),
        .i_addr  (tbl_addr),
        .i_wdata (table_value),
        .o_rdata (tbl_rdata)
    );

    uses_score u_score (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1        (s1),
        .i_tv        (tbl_rdata),
        .i_threshold (r_threshold),
        .i_m_tready  (i_m_tready),
        .o_stall     (stall),
        .o_m_tvalid  (o_m_tvalid),
        .o_best      (best),
        .o_passes    (passes),
        .o_tag       (result_tag)
    );

    assign o_m_tdata = {{M_PAD_W{1'b0}}, result_tag, passes, best};

endmodule

// ===== design/uses_table.sv =====
// Substitution score table memory with one registered read or write per cycle.
module uses_table import uses_pkg::*; (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [TBL_AW-1:0] i_addr,
    input  t_tv               i_wdata,
    output t_tv               o_rdata
);

    t_tv r_mem [TBL_DEPTH];
    t_tv r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/uses_ctrl.sv =====
// Side tracking, pair limits and table addressing for accepted items.
module uses_ctrl import uses_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [OP_W-1:0]     i_op,
    input  logic [LETTER_W-1:0] i_letter_a,
    input  logic [LETTER_W-1:0] i_letter_b,
    input  logic [TAG_W-1:0]    i_tag,
    input  logic [PAIR_W-1:0]   i_right_limit,
    input  logic [PAIR_W-1:0]   i_left_limit,
    input  logic                i_advance,
    output logic                o_tbl_we,
    output logic                o_tbl_re,
    output logic [TBL_AW-1:0]   o_tbl_addr,
    output t_pair_ctl           o_s1
);

    logic              r_in_left;
    logic              n_in_left;
    logic [PAIR_W-1:0] r_pairs;
    logic [PAIR_W-1:0] n_pairs;
    t_pair_ctl         r_s1;
    t_pair_ctl         n_s1;
    logic              in_alpha;
    logic [PAIR_W-1:0] pair_base;

    assign in_alpha = ({1'b0, i_letter_a} < (LETTER_W + 1)'(ALPHABET_SIZE)) &&
                      ({1'b0, i_letter_b} < (LETTER_W + 1)'(ALPHABET_SIZE));
    assign o_tbl_addr = TBL_AW'(TBL_AW'(i_letter_a) * TBL_AW'(ALPHABET_SIZE)) +
                        TBL_AW'(i_letter_b);
    assign o_tbl_we = i_accept && (i_op == OP_WRITE) && in_alpha;
    assign o_tbl_re = i_accept && ((i_op == OP_RIGHT) || (i_op == OP_LEFT));

    always_comb begin
        n_in_left = r_in_left;
        n_pairs   = r_pairs;
        pair_base = r_pairs;
        n_s1      = r_s1;
        if (i_advance) begin
            n_s1.valid = 1'b0;
        end
        if (i_accept) begin
            n_s1          = '0;
            n_s1.tag      = i_tag;
            n_s1.in_alpha = in_alpha;
            unique case (i_op)
                OP_WRITE: begin
                end
                OP_RIGHT: begin
                    n_s1.count = !r_in_left && (r_pairs < i_right_limit);
                    n_pairs    = r_pairs + PAIR_W'(n_s1.count);
                end
                OP_LEFT: begin
                    n_s1.restart = !r_in_left;
                    pair_base    = r_in_left ? r_pairs : '0;
                    n_s1.count   = pair_base < i_left_limit;
                    n_pairs      = pair_base + PAIR_W'(n_s1.count);
                    n_in_left    = 1'b1;
                end
                OP_FINISH: begin
                    n_s1.fin  = 1'b1;
                    n_pairs   = '0;
                    n_in_left = 1'b0;
                end
                default: begin
                end
            endcase
            n_s1.valid = n_s1.fin || n_s1.restart || n_s1.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_left <= 1'b0;
            r_pairs   <= '0;
            r_s1      <= '0;
        end else begin
            r_in_left <= n_in_left;
            r_pairs   <= n_pairs;
            r_s1      <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

// ===== design/uses_score.sv =====
// Running and best score update with saturation, and the result register.
module uses_score import uses_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_pair_ctl               i_s1,
    input  t_tv                     i_tv,
    input  logic signed [THR_W-1:0] i_threshold,
    input  logic                    i_m_tready,
    output logic                    o_stall,
    output logic                    o_m_tvalid,
    output logic [OUT_W-1:0]        o_best,
    output logic                    o_passes,
    output logic [TAG_W-1:0]        o_tag
);

    t_score                         r_running;
    t_score                         n_running;
    t_score                         r_best;
    t_score                         n_best;
    logic                           r_o_valid;
    logic                           n_o_valid;
    logic [OUT_W-1:0]               r_o_best;
    logic                           r_o_passes;
    logic [TAG_W-1:0]               r_o_tag;
    t_score                         base;
    logic signed [SCORE_WIDTH:0]    sum;
    t_score                         sat;
    logic signed [CMP_W-1:0]        best_x;
    logic signed [CMP_W-1:0]        thr_x;
    logic                           load_out;

    assign o_stall  = i_s1.valid && i_s1.fin && r_o_valid && !i_m_tready;
    assign load_out = i_s1.valid && i_s1.fin && !o_stall;
    assign best_x   = CMP_W'(r_best);
    assign thr_x    = CMP_W'(i_threshold);

    always_comb begin
        base = i_s1.restart ? r_best : r_running;
        sum  = (SCORE_WIDTH + 1)'(base) + (SCORE_WIDTH + 1)'(i_tv);
        if (sum[SCORE_WIDTH] != sum[SCORE_WIDTH-1]) begin
            sat = sum[SCORE_WIDTH] ? {1'b1, {(SCORE_WIDTH - 1){1'b0}}}
                                   : {1'b0, {(SCORE_WIDTH - 1){1'b1}}};
        end else begin
            sat = sum[SCORE_WIDTH-1:0];
        end
        n_running = r_running;
        n_best    = r_best;
        n_o_valid = r_o_valid && !i_m_tready;
        if (i_s1.valid && !o_stall) begin
            if (i_s1.fin) begin
                n_running = '0;
                n_best    = '0;
                n_o_valid = 1'b1;
            end else begin
                n_running = (i_s1.count && i_s1.in_alpha) ? sat : base;
                n_best    = (n_running > r_best) ? n_running : r_best;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= '0;
            r_best    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_running <= n_running;
            r_best    <= n_best;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_best   <= best_x[OUT_W-1:0];
            r_o_passes <= best_x >= thr_x;
            r_o_tag    <= i_s1.tag;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_best     = r_o_best;
    assign o_passes   = r_o_passes;
    assign o_tag      = r_o_tag;

    a_best_bounds_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best >= r_running)
        else $error("Best score fell below the running score.");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (r_best == '0) && (r_running == '0) && r_o_valid)
        else $error("Finish did not clear the hit state or post a result.");

    a_restart_takes_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s1.valid && !i_s1.fin && i_s1.restart && !i_s1.count && !o_stall)
        |=> (r_running == r_best))
        else $error("Left side restart did not start from the best score.");

endmodule

// ===== dv/tb_top.sv =====
// Testbench of the ungapped seed extension scorer: predicts every hit score and checks each result.
module tb_top import uses_pkg::*; ();

    localparam int IDLE_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        t_score           best;
        logic             passes;
        logic [TAG_W-1:0] tag;
    } t_hit_result;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tready = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [M_TDATA_W-1:0]  o_m_tdata;

    t_tv         subst_table [TBL_DEPTH];
    int          hit_running = 0;
    int          hit_best = 0;
    bit          on_left = 1'b0;
    int          side_count = 0;
    t_score      score_thr = '0;
    int          right_limit = 1023;
    int          left_limit = 1023;
    t_hit_result finish_q [$];

    int errors = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int hold_cycles = 0;
    int pattern_mode = 0;
    int pattern_left = 0;

    ungapped_seed_extension_scorer_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Pairs outside the directed test only use letters from a small set whose table entries are all written first.
    function automatic logic [LETTER_W-1:0] letter_of(input int k);
        return (k == 3) ? LETTER_W'(ALPHABET_SIZE - 1) : LETTER_W'(k * 10);
    endfunction

    function automatic logic [LETTER_W-1:0] pick_letter();
        return letter_of(int'($urandom_range(0, 3)));
    endfunction

    function automatic logic [LETTER_W-1:0] rand_letter();
        return LETTER_W'($urandom);
    endfunction

    function automatic logic [TV_W-1:0] rand_tv();
        return TV_W'($urandom);
    endfunction

    function automatic logic [TAG_W-1:0] rand_tag();
        return TAG_W'($urandom);
    endfunction

    function automatic logic [OP_W-1:0] rand_op();
        return OP_W'($urandom_range(0, 3));
    endfunction

    task automatic predict_item(input logic [OP_W-1:0] op, input logic [LETTER_W-1:0] a,
                                input logic [LETTER_W-1:0] b, input logic [TV_W-1:0] tv,
                                input logic [TAG_W-1:0] tag);
        t_hit_result res;
        int entry;
        bit take;
        entry = int'(a) * ALPHABET_SIZE + int'(b);
        take = 1'b0;
        case (op)
            OP_WRITE: subst_table[entry] = tv;
            OP_FINISH: begin
                res.best = hit_best[OUT_W-1:0];
                res.passes = (hit_best >= score_thr);
                res.tag = tag;
                finish_q.push_back(res);
                hit_running = 0;
                hit_best = 0;
                on_left = 1'b0;
                side_count = 0;
            end
            OP_RIGHT: take = !on_left && (side_count < right_limit);
            default: begin
                if (!on_left) begin
                    on_left = 1'b1;
                    hit_running = hit_best;
                    side_count = 0;
                end
                take = (side_count < left_limit);
            end
        endcase
        if (take) begin
            side_count++;
            hit_running = hit_running + subst_table[entry];
            if (hit_running > 32767) hit_running = 32767;
            if (hit_running < -32768) hit_running = -32768;
            if (hit_running > hit_best) hit_best = hit_running;
        end
    endtask

    task automatic send_item(input logic [OP_W-1:0] op, input logic [LETTER_W-1:0] a,
                             input logic [LETTER_W-1:0] b, input logic [TV_W-1:0] tv,
                             input logic [TAG_W-1:0] tag);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, tag, tv, b, a};
        @(posedge clk);
        while (!o_s_tready) @(posedge clk);
        predict_item(op, a, b, tv, tag);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (finish_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_THRESHOLD:   score_thr = data;
            REG_RIGHT_LIMIT: right_limit = int'(data[PAIR_W-1:0]);
            default:         left_limit = int'(data[PAIR_W-1:0]);
        endcase
        @(posedge clk);
    endtask

    task automatic test_table_fill();
        for (int a = 0; a < 4; a++) begin
            for (int b = 0; b < 4; b++) begin
                send_item(OP_WRITE, letter_of(a), letter_of(b), rand_tv(), rand_tag());
            end
        end
    endtask

    task automatic test_directed();
        send_item(OP_WRITE, 5'd0, 5'd0, 8'h7f, 16'h0000);
        send_item(OP_WRITE, 5'd31, 5'd31, 8'h80, 16'hffff);
        send_item(OP_WRITE, 5'd21, 5'd10, 8'h01, 16'h5555);
        send_item(OP_WRITE, 5'd10, 5'd21, 8'hff, 16'haaaa);
        send_item(OP_FINISH, 5'd0, 5'd0, 8'h00, 16'hffff);
        send_item(OP_RIGHT, 5'd0, 5'd0, 8'h00, 16'h0000);
        send_item(OP_RIGHT, 5'd0, 5'd0, 8'hff, 16'hffff);
        send_item(OP_RIGHT, 5'd31, 5'd31, 8'h00, 16'h0000);
        send_item(OP_FINISH, 5'd31, 5'd31, 8'hff, 16'h0000);
        send_item(OP_LEFT, 5'd21, 5'd10, 8'h00, 16'h0000);
        send_item(OP_LEFT, 5'd10, 5'd21, 8'h00, 16'h0000);
        send_item(OP_LEFT, 5'd0, 5'd0, 8'h00, 16'h0000);
        send_item(OP_FINISH, 5'd21, 5'd10, 8'h00, 16'h5555);
        send_item(OP_RIGHT, 5'd0, 5'd0, 8'h00, 16'h0000);
        send_item(OP_LEFT, 5'd31, 5'd31, 8'h00, 16'h0000);
        send_item(OP_RIGHT, 5'd0, 5'd0, 8'h00, 16'h0000);
        send_item(OP_LEFT, 5'd0, 5'd0, 8'h00, 16'h0000);
        send_item(OP_FINISH, 5'd10, 5'd21, 8'h00, 16'haaaa);
        send_item(OP_RIGHT, 5'd31, 5'd31, 8'h00, 16'h0000);
        send_item(OP_RIGHT, 5'd31, 5'd31, 8'h00, 16'h0000);
        send_item(OP_FINISH, 5'd0, 5'd0, 8'h00, 16'h1234);
    endtask

    task automatic test_side_limits();
        settle();
        write_reg(REG_THRESHOLD, 16'h7fff);
        write_reg(REG_RIGHT_LIMIT, 16'd0);
        write_reg(REG_LEFT_LIMIT, 16'd0);
        send_item(OP_RIGHT, 5'd0, 5'd0, rand_tv(), rand_tag());
        send_item(OP_LEFT, 5'd0, 5'd0, rand_tv(), rand_tag());
        send_item(OP_FINISH, rand_letter(), rand_letter(), rand_tv(), rand_tag());
        for (int i = 0; i < 3; i++) begin
            settle();
            write_reg(REG_THRESHOLD, (i == 0) ? 16'h8000 : 16'(635 + i - 1));
            write_reg(REG_RIGHT_LIMIT, 16'd3);
            write_reg(REG_LEFT_LIMIT, 16'd2);
            repeat (5) send_item(OP_RIGHT, 5'd0, 5'd0, rand_tv(), rand_tag());
            repeat (4) send_item(OP_LEFT, 5'd0, 5'd0, rand_tv(), rand_tag());
            send_item(OP_FINISH, rand_letter(), rand_letter(), rand_tv(), rand_tag());
        end
    endtask

    task automatic test_saturation();
        settle();
        write_reg(REG_THRESHOLD, 16'd0);
        write_reg(REG_RIGHT_LIMIT, 16'hffff);
        write_reg(REG_LEFT_LIMIT, 16'hffff);
        repeat (260) send_item(OP_RIGHT, 5'd0, 5'd0, rand_tv(), rand_tag());
        repeat (2) send_item(OP_LEFT, 5'd0, 5'd0, rand_tv(), rand_tag());
        send_item(OP_FINISH, rand_letter(), rand_letter(), rand_tv(), rand_tag());
    endtask

    task automatic test_random_hits();
        logic [CFG_DATA_W-1:0] cfg_word;
        int sent;
        int nr;
        int nl;
        for (int phase = 0; phase < 6; phase++) begin
            settle();
            case (phase)
                0:       cfg_word = 16'h8000;
                1:       cfg_word = 16'h7fff;
                default: cfg_word = 16'($urandom_range(0, 500) - 100);
            endcase
            write_reg(REG_THRESHOLD, cfg_word);
            cfg_word = CFG_DATA_W'($urandom);
            cfg_word[PAIR_W-1:0] = (phase == 2) ? LIMIT_RESET : PAIR_W'($urandom_range(0, 6));
            write_reg(REG_RIGHT_LIMIT, cfg_word);
            cfg_word = CFG_DATA_W'($urandom);
            cfg_word[PAIR_W-1:0] = (phase == 3) ? LIMIT_RESET : PAIR_W'($urandom_range(0, 6));
            write_reg(REG_LEFT_LIMIT, cfg_word);
            sent = 0;
            while (sent < 8) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item(rand_op(), pick_letter(), pick_letter(), rand_tv(), rand_tag());
                    sent++;
                end else begin
                    nr = $urandom_range(0, 5);
                    nl = $urandom_range(0, 5);
                    repeat (nr) begin
                        if ($urandom_range(0, 7) == 0)
                            send_item(OP_WRITE, pick_letter(), pick_letter(), rand_tv(),
                                      rand_tag());
                        send_item(OP_RIGHT, pick_letter(), pick_letter(), rand_tv(), rand_tag());
                    end
                    repeat (nl) begin
                        send_item(OP_LEFT, pick_letter(), pick_letter(), rand_tv(), rand_tag());
                        if ($urandom_range(0, 5) == 0)
                            send_item(OP_RIGHT, pick_letter(), pick_letter(), rand_tv(),
                                      rand_tag());
                    end
                    send_item(OP_FINISH, rand_letter(), rand_letter(), rand_tv(), rand_tag());
                    sent += nr + nl + 1;
                end
            end
        end
    endtask

    // The receiver holds off long enough for finished hits to back up into the input.
    task automatic test_output_stall();
        settle();
        hold_cycles = 300;
        repeat (12) begin
            send_item(OP_RIGHT, pick_letter(), pick_letter(), rand_tv(), rand_tag());
            send_item(OP_FINISH, rand_letter(), rand_letter(), rand_tv(), rand_tag());
        end
    endtask

    always @(posedge clk) begin
        if (pattern_left == 0) begin
            pattern_mode = $urandom_range(0, 3);
            pattern_left = $urandom_range(20, 80);
        end else begin
            pattern_left--;
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_tready <= 1'b0;
        end else begin
            case (pattern_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 1) == 1);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((pattern_left % 16) == 0);
            endcase
        end
    end

    always @(posedge clk) begin : check_result
        t_hit_result want;
        if (rst_n && o_m_tvalid && m_tready) begin
            if (finish_q.size() == 0) begin
                $error("result transfer with no hit pending");
                errors++;
            end else begin
                want = finish_q.pop_front();
                if (o_m_tdata[OUT_W-1:0] !== want.best) begin
                    $error("best_score expected %0d got %0d", want.best,
                           $signed(o_m_tdata[OUT_W-1:0]));
                    errors++;
                end
                if (o_m_tdata[OUT_W] !== want.passes) begin
                    $error("passes expected %0d got %0d", want.passes, o_m_tdata[OUT_W]);
                    errors++;
                end
                if (o_m_tdata[OUT_W+TAG_W:OUT_W+1] !== want.tag) begin
                    $error("result_tag expected %h got %h", want.tag,
                           o_m_tdata[OUT_W+TAG_W:OUT_W+1]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_table_fill();
        test_directed();
        test_side_limits();
        test_saturation();
        test_random_hits();
        test_output_stall();
        settle();
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
